### sv/rapf_pkg.sv
// ----------------------------------------------------------------------------
// rapf_pkg - shared types and constants for the Fenwick range-add block
// Sizes of the cell store, position and value widths, and the command word
// that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package rapf_pkg;

    localparam int SIZE    = 1024;
    localparam int ADDR_W  = $clog2(SIZE);
    // walk index: holds SIZE and end+1 up to twice SIZE
    localparam int IDX_W   = ADDR_W + 2;
    localparam int POS_W   = 11;
    localparam int AMT_W   = 32;
    localparam int VAL_W   = 64;
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic               is_query;
        logic [IDX_W-1:0]   pos_a;    // add start, or query position
        logic [IDX_W-1:0]   pos_b;    // add end + 1
        logic [VAL_W-1:0]   amount;   // sign-extended add amount
    } t_cmd;

endpackage

### sv/range_add_point_query_fenwick.sv
// ----------------------------------------------------------------------------
// range_add_point_query_fenwick - Fenwick tree, range add and point query
// After reset the block runs a clearing pass over its 1024 cells and holds
// busy high throughout that pass. A range add walks the tree upward from the start
// position and from end+1, one cell per cycle through a cell store with one
// read and one write port. A query walks down summing cells. Items are queued
// two deep ahead of the walker; busy goes high when that queue is full. A query
// result appears on o_point_value with o_valid high for exactly one cycle and
// cannot be held off.
// ----------------------------------------------------------------------------
module range_add_point_query_fenwick (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_opcode,
    input  logic [rapf_pkg::POS_W-1:0]        i_range_start,
    input  logic [rapf_pkg::POS_W-1:0]        i_range_end,
    input  logic signed [rapf_pkg::AMT_W-1:0] i_add_amount,
    input  logic [rapf_pkg::POS_W-1:0]        i_query_index,
    output logic                              o_valid,
    output logic signed [rapf_pkg::VAL_W-1:0] o_point_value
);

    logic            clearing;
    logic            pop;
    logic            cmd_valid;
    rapf_pkg::t_cmd  cmd;

    rapf_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_opcode      (i_opcode),
        .i_range_start (i_range_start),
        .i_range_end   (i_range_end),
        .i_add_amount  (i_add_amount),
        .i_query_index (i_query_index),
        .i_hold        (clearing),
        .i_pop         (pop),
        .o_busy        (busy),
        .o_cmd_valid   (cmd_valid),
        .o_cmd         (cmd)
    );

    rapf_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (cmd_valid),
        .i_cmd         (cmd),
        .o_pop         (pop),
        .o_clearing    (clearing),
        .o_valid       (o_valid),
        .o_point_value (o_point_value)
    );

endmodule

### sv/rapf_front.sv
// ----------------------------------------------------------------------------
// rapf_front - command intake and queue
// Takes items on the start/busy handshake, turns each into a walk command
// (clamped positions, sign-extended amount) and holds it in a small queue.
// ----------------------------------------------------------------------------
module rapf_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_opcode,
    input  logic [rapf_pkg::POS_W-1:0]    i_range_start,
    input  logic [rapf_pkg::POS_W-1:0]    i_range_end,
    input  logic signed [rapf_pkg::AMT_W-1:0] i_add_amount,
    input  logic [rapf_pkg::POS_W-1:0]    i_query_index,
    input  logic                          i_hold,
    input  logic                          i_pop,
    output logic                          o_busy,
    output logic                          o_cmd_valid,
    output rapf_pkg::t_cmd                o_cmd
);

    rapf_pkg::t_cmd                   r_q [rapf_pkg::QDEPTH];
    logic [rapf_pkg::QPTR_W-1:0]      r_wp, n_wp;
    logic [rapf_pkg::QPTR_W-1:0]      r_rp, n_rp;
    logic [rapf_pkg::QCNT_W-1:0]      r_cnt, n_cnt;
    logic                             push;
    logic                             pop;
    rapf_pkg::t_cmd                   cmd_in;
    logic [rapf_pkg::IDX_W-1:0]       start_x;
    logic [rapf_pkg::IDX_W-1:0]       qidx_x;

    assign o_busy      = i_hold || (r_cnt == rapf_pkg::QCNT_W'(rapf_pkg::QDEPTH));
    assign push        = i_start && !o_busy;
    assign pop         = i_pop && (r_cnt != '0);
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];

    always_comb begin
        start_x = rapf_pkg::IDX_W'(i_range_start);
        qidx_x  = rapf_pkg::IDX_W'(i_query_index);
        cmd_in.is_query = (i_opcode == rapf_pkg::OP_QUERY);
        cmd_in.amount   = {{(rapf_pkg::VAL_W-rapf_pkg::AMT_W){i_add_amount[rapf_pkg::AMT_W-1]}},
                           i_add_amount};
        cmd_in.pos_b    = rapf_pkg::IDX_W'(i_range_end) + rapf_pkg::IDX_W'(1);
        if (cmd_in.is_query) begin
            // positions past the end read as the last position
            cmd_in.pos_a = (qidx_x > rapf_pkg::IDX_W'(rapf_pkg::SIZE)) ?
                           rapf_pkg::IDX_W'(rapf_pkg::SIZE) : qidx_x;
        end else begin
            cmd_in.pos_a = (start_x == '0) ? rapf_pkg::IDX_W'(1) : start_x;
        end
    end

    always_comb begin
        n_wp  = push ? r_wp + rapf_pkg::QPTR_W'(1) : r_wp;
        n_rp  = pop  ? r_rp + rapf_pkg::QPTR_W'(1) : r_rp;
        n_cnt = r_cnt + rapf_pkg::QCNT_W'(push) - rapf_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd_in;
        end
    end

endmodule

### sv/rapf_back.sv
// ----------------------------------------------------------------------------
// rapf_back - tree walker and cell store
// Runs the clearing pass after reset, then pops commands and walks the tree:
// two upward walks per range add, one downward summing walk per query.
// Reads overlap the read-modify-write of the previous cell.
// ----------------------------------------------------------------------------
module rapf_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cmd_valid,
    input  rapf_pkg::t_cmd                    i_cmd,
    output logic                              o_pop,
    output logic                              o_clearing,
    output logic                              o_valid,
    output logic signed [rapf_pkg::VAL_W-1:0] o_point_value
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_UP_A  = 3'd2;
    localparam logic [2:0] ST_UP_B  = 3'd3;
    localparam logic [2:0] ST_DOWN  = 3'd4;

    logic [rapf_pkg::VAL_W-1:0]   r_mem [rapf_pkg::SIZE];

    logic [2:0]                   r_state, n_state;
    logic [rapf_pkg::ADDR_W-1:0]  r_clr, n_clr;
    logic [rapf_pkg::IDX_W-1:0]   r_idx, n_idx;
    logic [rapf_pkg::IDX_W-1:0]   r_pos_b, n_pos_b;
    logic [rapf_pkg::VAL_W-1:0]   r_amt, n_amt;
    logic [rapf_pkg::VAL_W-1:0]   r_acc, n_acc;
    logic                         r_is_q, n_is_q;
    logic                         r_pend, n_pend;
    logic [rapf_pkg::ADDR_W-1:0]  r_pend_addr, n_pend_addr;
    logic [rapf_pkg::VAL_W-1:0]   r_rdata;
    logic                         r_out_valid, n_out_valid;
    logic [rapf_pkg::VAL_W-1:0]   r_out_value, n_out_value;

    logic                         rd_en;
    logic [rapf_pkg::ADDR_W-1:0]  rd_addr;
    logic                         we;
    logic [rapf_pkg::ADDR_W-1:0]  wa;
    logic [rapf_pkg::VAL_W-1:0]   wd;
    logic [rapf_pkg::IDX_W-1:0]   low_bit;
    logic                         up_ok;

    assign o_clearing    = (r_state == ST_CLEAR);
    assign o_valid       = r_out_valid;
    assign o_point_value = r_out_value;

    assign low_bit = r_idx & (~r_idx + rapf_pkg::IDX_W'(1));
    assign up_ok   = (r_idx != '0) && (r_idx <= rapf_pkg::IDX_W'(rapf_pkg::SIZE));
    assign rd_addr = rapf_pkg::ADDR_W'(r_idx - rapf_pkg::IDX_W'(1));

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_idx       = r_idx;
        n_pos_b     = r_pos_b;
        n_amt       = r_amt;
        n_acc       = r_acc;
        n_is_q      = r_is_q;
        n_pend      = 1'b0;
        n_pend_addr = r_pend_addr;
        n_out_valid = 1'b0;
        n_out_value = r_out_value;
        o_pop       = 1'b0;
        rd_en       = 1'b0;
        // finish the read-modify-write of the cell read last cycle
        we          = r_pend && !r_is_q;
        wa          = r_pend_addr;
        wd          = r_rdata + r_amt;

        unique case (r_state) inside
            ST_CLEAR: begin
                we    = 1'b1;
                wa    = r_clr;
                wd    = '0;
                n_clr = r_clr + rapf_pkg::ADDR_W'(1);
                if (r_clr == rapf_pkg::ADDR_W'(rapf_pkg::SIZE - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    o_pop   = 1'b1;
                    n_is_q  = i_cmd.is_query;
                    n_idx   = i_cmd.pos_a;
                    n_pos_b = i_cmd.pos_b;
                    n_amt   = i_cmd.amount;
                    n_acc   = '0;
                    n_state = i_cmd.is_query ? ST_DOWN : ST_UP_A;
                end
            end
            ST_UP_A, ST_UP_B: begin
                if (up_ok) begin
                    rd_en       = 1'b1;
                    n_pend      = 1'b1;
                    n_pend_addr = rd_addr;
                    n_idx       = r_idx + low_bit;
                end else if (r_state == ST_UP_A) begin
                    // last write lands this cycle; second walk reads from next
                    n_idx   = r_pos_b;
                    n_amt   = ~r_amt + rapf_pkg::VAL_W'(1);
                    n_state = ST_UP_B;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_DOWN: begin
                if (r_pend) begin
                    n_acc = r_acc + r_rdata;
                end
                if (r_idx != '0) begin
                    rd_en       = 1'b1;
                    n_pend      = 1'b1;
                    n_pend_addr = rd_addr;
                    n_idx       = r_idx & (r_idx - rapf_pkg::IDX_W'(1));
                end else begin
                    n_out_valid = 1'b1;
                    n_out_value = r_pend ? r_acc + r_rdata : r_acc;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
            r_is_q      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            r_is_q      <= n_is_q;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_pos_b     <= n_pos_b;
        r_amt       <= n_amt;
        r_acc       <= n_acc;
        r_pend_addr <= n_pend_addr;
        r_out_value <= n_out_value;
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wa] <= wd;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

endmodule

### bench/range_add_point_query_fenwick_test.sv
// ----------------------------------------------------------------------------
// range_add_point_query_fenwick_test - testbench for the Fenwick range-add block
// A driver feeds range adds and point queries from a pending queue, in random
// bursts. A shadow copy of the tree cells predicts each point value as the
// command is accepted. A monitor checks every strobed result against the
// oldest predicted value. A short directed prologue hits the edge positions and
// amounts, and a random body of about 400 commands follows.
// ----------------------------------------------------------------------------
module range_add_point_query_fenwick_test;

    localparam int TREE_SIZE    = rapf_pkg::SIZE;
    localparam int RANDOM_CMDS  = 400;
    localparam int LIMIT_CYCLES = 200000;
    localparam int SETTLE_WAIT  = 64;

    typedef struct {
        logic                        op;
        logic [rapf_pkg::POS_W-1:0]  range_start;
        logic [rapf_pkg::POS_W-1:0]  range_end;
        logic [rapf_pkg::AMT_W-1:0]  amount;
        logic [rapf_pkg::POS_W-1:0]  query_index;
        bit                          drain_first;
    } t_fenwick_cmd;

    typedef struct {
        logic [rapf_pkg::POS_W-1:0]  index;
        logic [rapf_pkg::VAL_W-1:0]  value;
    } t_point_value;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               start = 1'b0;
    logic                               busy;
    logic                               i_opcode = rapf_pkg::OP_ADD;
    logic [rapf_pkg::POS_W-1:0]         i_range_start = '0;
    logic [rapf_pkg::POS_W-1:0]         i_range_end = '0;
    logic signed [rapf_pkg::AMT_W-1:0]  i_add_amount = '0;
    logic [rapf_pkg::POS_W-1:0]         i_query_index = '0;
    logic                               o_valid;
    logic signed [rapf_pkg::VAL_W-1:0]  o_point_value;

    t_fenwick_cmd                pending_cmds[$];
    t_point_value                expected_values[$];
    logic [rapf_pkg::VAL_W-1:0]  shadow_cells[1:TREE_SIZE];
    int                          cmds_total = 0;
    int                          cmds_accepted = 0;
    int                          mismatch_count = 0;
    int                          cycle_count = 0;
    int                          burst_left = 1;
    int                          gap_left = 0;

    range_add_point_query_fenwick uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_opcode      (i_opcode),
        .i_range_start (i_range_start),
        .i_range_end   (i_range_end),
        .i_add_amount  (i_add_amount),
        .i_query_index (i_query_index),
        .o_valid       (o_valid),
        .o_point_value (o_point_value)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ---- shadow tree ----
    function automatic void fenwick_point_add(input int unsigned pos,
                                              input logic [rapf_pkg::VAL_W-1:0] amt);
        int unsigned i;
        i = pos;
        if (i == 0) return;
        while (i <= TREE_SIZE) begin
            shadow_cells[i] = shadow_cells[i] + amt;
            i = i + (i & (~i + 1));
        end
    endfunction

    function automatic logic [rapf_pkg::VAL_W-1:0] fenwick_prefix(input int unsigned pos);
        logic [rapf_pkg::VAL_W-1:0] acc;
        int unsigned                i;
        acc = '0;
        i = (pos > TREE_SIZE) ? TREE_SIZE : pos;
        while (i > 0) begin
            acc = acc + shadow_cells[i];
            i = i - (i & (~i + 1));
        end
        return acc;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        mismatch_count++;
    endtask

    // ---- stimulus helpers ----
    function automatic logic [rapf_pkg::POS_W-1:0] random_position();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return $urandom_range(TREE_SIZE + 1, 2047);
            2:       return TREE_SIZE;
            3:       return 1;
            default: return $urandom_range(1, TREE_SIZE);
        endcase
    endfunction

    function automatic logic [rapf_pkg::AMT_W-1:0] random_amount();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return $urandom_range(0, 31) - 16;
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_add(input logic [rapf_pkg::POS_W-1:0] rs,
                             input logic [rapf_pkg::POS_W-1:0] re,
                             input logic [rapf_pkg::AMT_W-1:0] amt,
                             input bit drain);
        t_fenwick_cmd c;
        c.op = rapf_pkg::OP_ADD;
        c.range_start = rs;
        c.range_end = re;
        c.amount = amt;
        c.query_index = $urandom;  // ignored by an add
        c.drain_first = drain;
        pending_cmds.push_back(c);
        cmds_total++;
    endtask

    task automatic queue_query(input logic [rapf_pkg::POS_W-1:0] qi, input bit drain);
        t_fenwick_cmd c;
        c.op = rapf_pkg::OP_QUERY;
        c.range_start = $urandom;
        c.range_end = $urandom;
        c.amount = $urandom;
        c.query_index = qi;
        c.drain_first = drain;
        pending_cmds.push_back(c);
        cmds_total++;
    endtask

    // ---- driver ----
    always @(posedge i_clk) begin : driver
        t_fenwick_cmd  c;
        t_point_value  pv;
        bit            accepted;
        bit            drive;
        int unsigned   first_pos;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            accepted = start && !busy;
            if (accepted) begin
                c = pending_cmds.pop_front();
                cmds_accepted++;
                if (c.op == rapf_pkg::OP_QUERY) begin
                    pv.index = c.query_index;
                    pv.value = fenwick_prefix(c.query_index);
                    expected_values.push_back(pv);
                end else begin
                    first_pos = (c.range_start == 0) ? 1 : c.range_start;
                    fenwick_point_add(first_pos, {{32{c.amount[31]}}, c.amount});
                    fenwick_point_add(c.range_end + 1, -{{32{c.amount[31]}}, c.amount});
                end
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                                             : $urandom_range(1, 10);
                    case ($urandom_range(0, 9)) inside
                        [0:3]:   gap_left = 0;
                        [4:7]:   gap_left = $urandom_range(1, 3);
                        8:       gap_left = $urandom_range(4, 15);
                        default: gap_left = $urandom_range(20, 40);
                    endcase
                end
            end
            drive = 1'b0;
            if (start && !accepted) begin
                drive = 1'b1;  // hold the beat until it is taken
            end else if (gap_left > 0) begin
                gap_left--;
            end else if (pending_cmds.size() > 0) begin
                drive = !(pending_cmds[0].drain_first && expected_values.size() != 0);
            end
            start <= drive;
            if (drive) begin
                i_opcode      <= pending_cmds[0].op;
                i_range_start <= pending_cmds[0].range_start;
                i_range_end   <= pending_cmds[0].range_end;
                i_add_amount  <= pending_cmds[0].amount;
                i_query_index <= pending_cmds[0].query_index;
            end
        end
    end

    // ---- monitor ----
    always @(posedge i_clk) begin : monitor
        t_point_value pv;
        if (i_rst_n && o_valid) begin
            if (expected_values.size() == 0) begin
                report_mismatch($sformatf("unexpected point value %0d", o_point_value));
            end else begin
                pv = expected_values.pop_front();
                if (o_point_value !== pv.value)
                    report_mismatch($sformatf("index %0d: got %0d, want %0d", pv.index,
                                              o_point_value, $signed(pv.value)));
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d of %0d commands taken",
                     cycle_count, cmds_accepted, cmds_total);
            $display("[range_add_point_query_fenwick] ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        logic [rapf_pkg::POS_W-1:0] rs;
        logic [rapf_pkg::POS_W-1:0] re;
        logic [rapf_pkg::POS_W-1:0] tmp;
        for (int i = 1; i <= TREE_SIZE; i++) shadow_cells[i] = '0;

        // directed: empty tree, edge positions, extreme amounts, odd ranges
        queue_query(0, 1'b0);
        queue_query(1, 1'b0);
        queue_query(TREE_SIZE, 1'b0);
        queue_query(2047, 1'b0);
        queue_add(1, TREE_SIZE, 32'h7fff_ffff, 1'b0);
        queue_add(0, 5, 32'h8000_0000, 1'b0);           // start zero acts as one
        queue_add(1500, 1030, 32'h0000_1234, 1'b0);     // both ends past the tree
        queue_add(10, 3, 32'hffff_fff9, 1'b0);          // start after end
        queue_add(TREE_SIZE, TREE_SIZE, 32'd5, 1'b0);
        queue_add(512, 2047, 32'h5555_5555, 1'b0);
        queue_add(700, 1023, 32'haaaa_aaaa, 1'b0);
        queue_query(1, 1'b0);
        queue_query(4, 1'b0);
        queue_query(6, 1'b0);
        queue_query(7, 1'b0);
        queue_query(10, 1'b0);
        queue_query(512, 1'b0);
        queue_query(1023, 1'b0);
        queue_query(TREE_SIZE, 1'b0);
        queue_query(1025, 1'b0);
        queue_query(0, 1'b0);

        // random body, mostly ordered ranges; a few drain points along the way
        for (int n = 0; n < RANDOM_CMDS; n++) begin
            if ($urandom_range(0, 99) < 55) begin
                rs = random_position();
                re = random_position();
                if (rs > re && $urandom_range(0, 4) != 0) begin
                    tmp = rs;
                    rs = re;
                    re = tmp;
                end
                queue_add(rs, re, random_amount(), n == 0 || $urandom_range(0, 99) == 0);
            end else begin
                queue_query(random_position(), n == 0 || $urandom_range(0, 99) == 0);
            end
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (cmds_accepted == cmds_total);
        while (expected_values.size() != 0) @(posedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("[range_add_point_query_fenwick] OK");
        end else begin
            $display("[range_add_point_query_fenwick] ERROR");
        end
        $finish;
    end

endmodule

### filelist.f
sv/rapf_pkg.sv
sv/rapf_front.sv
sv/rapf_back.sv
sv/range_add_point_query_fenwick.sv
bench/range_add_point_query_fenwick_test.sv
